### rtl/csbp_pkg.sv
// ----------------------------------------------------------------------------
// csbp_pkg - shared types and constants of the cycle shift block permuter
// Sizes of the element store and workspace, field widths, action and status
// codes, register indexes and the structs passed between the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package csbp_pkg;

    // store geometry
    localparam int MEM_DEPTH = 4096;
    localparam int BLOCK_MAX = 16;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int WORK_AW   = (BLOCK_MAX > 1) ? $clog2(BLOCK_MAX) : 1;

    // word field widths
    localparam int ACT_W  = 2;
    localparam int FLD_W  = 12;                // address and count fields
    localparam int DATA_W = 64;
    localparam int ELEM_W = 2 * DATA_W;        // {im, re}
    localparam int STAT_W = 2;

    // configuration widths
    localparam int ROWS_W = 13;
    localparam int COLS_W = 13;
    localparam int LEN_W  = 5;

    // internal widths
    localparam int BLK_W   = MEM_AW;                       // block index
    localparam int CNT_W   = (MEM_AW > FLD_W) ? MEM_AW : FLD_W;
    localparam int PROD_W  = ROWS_W + COLS_W;
    localparam int PLEN_W  = PROD_W + LEN_W;
    localparam int BASE_W  = BLK_W + LEN_W;
    localparam int MM_T_W  = BLK_W + 2;
    localparam int MM_BW   = $clog2(ROWS_W);

    // stream and APB widths
    localparam int S_TDATA_W = 2 * FLD_W + ELEM_W;
    localparam int M_TDATA_W = ELEM_W;
    localparam int PADDR_W   = 4;
    localparam int APB_DW    = 32;

    // action codes (s_tuser)
    localparam logic [ACT_W-1:0] ACT_WR_ELEM = 2'd0;
    localparam logic [ACT_W-1:0] ACT_RD_ELEM = 2'd1;
    localparam logic [ACT_W-1:0] ACT_WR_WORK = 2'd2;
    localparam logic [ACT_W-1:0] ACT_SHIFT   = 2'd3;

    // status codes (m_tuser)
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_ADDR  = 2'd1;
    localparam logic [STAT_W-1:0] ST_SHIFT = 2'd2;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_ROWS = 2'd0;
    localparam logic [1:0] REG_COLS = 2'd1;
    localparam logic [1:0] REG_BLEN = 2'd2;

    typedef struct packed {
        logic [ROWS_W-1:0] rows;
        logic [COLS_W-1:0] cols;
        logic [LEN_W-1:0]  block_len;
    } cfg_t;

    typedef struct packed {
        logic              start;
        logic [BLK_W-1:0]  k;
        logic [ROWS_W-1:0] mult;
        logic [BLK_W-1:0]  modulus;
    } mm_req_t;

    typedef struct packed {
        logic             done;
        logic [BLK_W-1:0] prod;
    } mm_rsp_t;

endpackage

`default_nettype wire

### rtl/cycle_shift_block_permuter.sv
// ----------------------------------------------------------------------------
// cycle_shift_block_permuter - block store with cycle-following shift
// Element store, one-block workspace and a sequencer that walks the chain
// k -> k*rows mod q, moving whole blocks, with a shared modular multiplier.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+-----------------------------------------
//  s_      | in  | s_tvalid/tready  | tuser: action; tdata: addr, cnt, re, im
//  m_      | out | m_tvalid/tready  | tuser: status; tdata: read_re, read_im
//  apb     | in  | psel/penable     | rows @0x0, cols @0x4, block_len @0x8
//
//  Element and workspace writes go from accept straight to the post; a read
//  passes a RAM read state first. Shift: product and check states, then per
//  move a modmul, a base step and a read/write pair per element, then a last
//  step (modmul too if a whole-cycle walk closes at s), workspace store, post.
//  Rate is set by the single RAM port pair and the bit-serial modmul.
//  Reset is synchronous, active low; no clearing pass (store undefined).
//  A new word is taken while the previous result waits in the output
//  register; a stalled result only holds the sequencer in its last state.
//
`default_nettype none

module cycle_shift_block_permuter (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // input words
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [11:0] address, [23:12] count, [87:24] data_re, [151:88] data_im
    input  wire logic [csbp_pkg::S_TDATA_W-1:0]  s_tdata,
    // [1:0] action
    input  wire logic [csbp_pkg::ACT_W-1:0]      s_tuser,
    // result words
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [63:0] read_re, [127:64] read_im
    output logic      [csbp_pkg::M_TDATA_W-1:0]  m_tdata,
    // [1:0] status
    output logic      [csbp_pkg::STAT_W-1:0]     m_tuser,
    // configuration
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [csbp_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [csbp_pkg::APB_DW-1:0]     pwdata,
    output logic      [csbp_pkg::APB_DW-1:0]     prdata,
    output logic                                 pready
);

    localparam int FW  = csbp_pkg::FLD_W;
    localparam int DW  = csbp_pkg::DATA_W;
    localparam int EW  = csbp_pkg::ELEM_W;
    localparam int AW  = csbp_pkg::MEM_AW;
    localparam int KW  = csbp_pkg::BLK_W;
    localparam int CW  = csbp_pkg::CNT_W;
    localparam int LW  = csbp_pkg::LEN_W;
    localparam int BW  = csbp_pkg::BASE_W;
    localparam int PW  = csbp_pkg::PROD_W;
    localparam int PLW = csbp_pkg::PLEN_W;
    localparam int SW  = csbp_pkg::STAT_W;

    // sequencer states, one-hot
    typedef enum logic [12:0] {
        ST_IDLE     = 13'b0000000000001,
        ST_ELEM_RD  = 13'b0000000000010,
        ST_MUL1     = 13'b0000000000100,
        ST_MUL2     = 13'b0000000001000,
        ST_CHECK    = 13'b0000000010000,
        ST_STEP     = 13'b0000000100000,
        ST_MMWAIT   = 13'b0000001000000,
        ST_BASE     = 13'b0000010000000,
        ST_CP_RD    = 13'b0000100000000,
        ST_CP_WR    = 13'b0001000000000,
        ST_FIN_BASE = 13'b0010000000000,
        ST_FIN_WR   = 13'b0100000000000,
        ST_DONE     = 13'b1000000000000
    } state_t;

    // input word fields
    logic [FW-1:0] s_addr;
    logic [FW-1:0] s_cnt;
    logic [DW-1:0] s_re;
    logic [DW-1:0] s_im;

    assign s_addr = s_tdata[FW-1:0];
    assign s_cnt  = s_tdata[2*FW-1:FW];
    assign s_re   = s_tdata[2*FW+DW-1:2*FW];
    assign s_im   = s_tdata[2*FW+2*DW-1:2*FW+DW];

    csbp_pkg::cfg_t    cfg;
    csbp_pkg::mm_req_t mm_req;
    csbp_pkg::mm_rsp_t mm_rsp;

    csbp_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    csbp_modmul u_modmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mm_req),
        .rsp     (mm_rsp)
    );

    // element store, {im, re}
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [EW-1:0] mem_rdata;

    csbp_ram #(
        .WIDTH (EW),
        .DEPTH (csbp_pkg::MEM_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // sequencer state
    state_t        state_reg, state_next;
    logic [FW-1:0] addr_reg, addr_next;       // start block s
    logic [FW-1:0] cnt_reg, cnt_next;
    logic [KW-1:0] k_reg, k_next;             // current block
    logic [KW-1:0] k1_reg, k1_next;           // next block in the chain
    logic [KW-1:0] q_reg, q_next;
    logic [CW-1:0] i_reg, i_next;             // moves done
    logic [CW-1:0] limit_reg, limit_next;     // move limit
    logic          cyc_reg, cyc_next;         // whole-cycle mode
    logic [LW-1:0] j_reg, j_next;             // element within block
    logic [BW-1:0] dst_base_reg, dst_base_next;
    logic [BW-1:0] src_base_reg, src_base_next;
    logic [PW-1:0] prod_reg, prod_next;
    logic [PLW-1:0] plen_reg, plen_next;

    // result staging and output register
    logic [EW-1:0] res_data_reg, res_data_next;
    logic [SW-1:0] res_st_reg, res_st_next;
    logic [EW-1:0] m_data_reg, m_data_next;
    logic [SW-1:0] m_st_reg, m_st_next;
    logic          m_valid_reg, m_valid_next;

    // workspace: 16 entries, written at one index, read at j
    logic [EW-1:0] work_reg [csbp_pkg::BLOCK_MAX];
    logic          work_we;

    logic          s_acc;
    logic          shift_bad;
    logic          out_free;
    logic          last_j;
    logic [BW-1:0] j_ext;

    assign s_acc    = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_tready;
    assign last_j   = (j_reg == (cfg.block_len - 1'b1));
    assign j_ext    = BW'(j_reg);

    // argument checks on registered products
    assign shift_bad = (prod_reg < PW'(2))
                    || (cfg.block_len == '0)
                    || (32'(cfg.block_len) > csbp_pkg::BLOCK_MAX)
                    || (32'(plen_reg) > csbp_pkg::MEM_DEPTH)
                    || (32'(addr_reg) >= (32'(prod_reg) - 32'd1));

    assign mm_req.k       = k_reg;
    assign mm_req.mult    = cfg.rows;
    assign mm_req.modulus = q_reg;
    assign mm_req.start   = (state_reg == ST_STEP) && (i_reg != limit_reg);

    assign work_we = s_acc && (s_tuser == csbp_pkg::ACT_WR_WORK)
                  && (32'(s_addr) < csbp_pkg::BLOCK_MAX);

    always_comb begin
        state_next    = state_reg;
        addr_next     = addr_reg;
        cnt_next      = cnt_reg;
        k_next        = k_reg;
        k1_next       = k1_reg;
        q_next        = q_reg;
        i_next        = i_reg;
        limit_next    = limit_reg;
        cyc_next      = cyc_reg;
        j_next        = j_reg;
        dst_base_next = dst_base_reg;
        src_base_next = src_base_reg;
        prod_next     = prod_reg;
        plen_next     = plen_reg;
        res_data_next = res_data_reg;
        res_st_next   = res_st_reg;
        m_data_next   = m_data_reg;
        m_st_next     = m_st_reg;
        m_valid_next  = m_valid_reg && !m_tready;

        mem_we    = 1'b0;
        mem_waddr = AW'(dst_base_reg + j_ext);
        mem_wdata = mem_rdata;
        mem_raddr = AW'(src_base_reg + j_ext);

        unique case (state_reg)
            ST_IDLE: begin
                mem_raddr = AW'(s_addr);
                mem_waddr = AW'(s_addr);
                mem_wdata = {s_im, s_re};
                if (s_acc) begin
                    addr_next     = s_addr;
                    cnt_next      = s_cnt;
                    res_data_next = '0;
                    res_st_next   = csbp_pkg::ST_OK;
                    unique case (s_tuser)
                        csbp_pkg::ACT_WR_ELEM: begin
                            if (32'(s_addr) < csbp_pkg::MEM_DEPTH) begin
                                mem_we = 1'b1;
                            end else begin
                                res_st_next = csbp_pkg::ST_ADDR;
                            end
                            state_next = ST_DONE;
                        end
                        csbp_pkg::ACT_RD_ELEM: begin
                            if (32'(s_addr) < csbp_pkg::MEM_DEPTH) begin
                                state_next = ST_ELEM_RD;
                            end else begin
                                res_st_next = csbp_pkg::ST_ADDR;
                                state_next  = ST_DONE;
                            end
                        end
                        csbp_pkg::ACT_WR_WORK: begin
                            if (!work_we) begin
                                res_st_next = csbp_pkg::ST_ADDR;
                            end
                            state_next = ST_DONE;
                        end
                        default: begin  // shift
                            state_next = ST_MUL1;
                        end
                    endcase
                end
            end
            ST_ELEM_RD: begin
                res_data_next = mem_rdata;
                state_next    = ST_DONE;
            end
            ST_MUL1: begin
                prod_next  = PW'(cfg.rows) * PW'(cfg.cols);
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                plen_next  = PLW'(prod_reg) * PLW'(cfg.block_len);
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (shift_bad) begin
                    res_st_next = csbp_pkg::ST_SHIFT;
                    state_next  = ST_DONE;
                end else begin
                    q_next     = KW'(prod_reg - 1'b1);
                    k_next     = KW'(addr_reg);
                    i_next     = '0;
                    cyc_next   = (cnt_reg == '0);
                    limit_next = (cnt_reg != '0) ? CW'(cnt_reg - 1'b1)
                                                 : CW'(prod_reg - 1'b1);
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                // modmul starts here unless the move limit is reached
                if (i_reg == limit_reg) begin
                    state_next = ST_FIN_BASE;
                end else begin
                    state_next = ST_MMWAIT;
                end
            end
            ST_MMWAIT: begin
                if (mm_rsp.done) begin
                    k1_next = mm_rsp.prod;
                    if (cyc_reg && (mm_rsp.prod == KW'(addr_reg))) begin
                        state_next = ST_FIN_BASE;   // chain closed at s
                    end else begin
                        state_next = ST_BASE;
                    end
                end
            end
            ST_BASE: begin
                dst_base_next = BW'(k_reg) * BW'(cfg.block_len);
                src_base_next = BW'(k1_reg) * BW'(cfg.block_len);
                j_next        = '0;
                state_next    = ST_CP_RD;
            end
            ST_CP_RD: begin
                state_next = ST_CP_WR;
            end
            ST_CP_WR: begin
                mem_we = 1'b1;
                if (last_j) begin
                    j_next     = '0;
                    k_next     = k1_reg;
                    i_next     = i_reg + 1'b1;
                    state_next = ST_STEP;
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_CP_RD;
                end
            end
            ST_FIN_BASE: begin
                dst_base_next = BW'(k_reg) * BW'(cfg.block_len);
                j_next        = '0;
                state_next    = ST_FIN_WR;
            end
            ST_FIN_WR: begin
                mem_we    = 1'b1;
                mem_wdata = work_reg[csbp_pkg::WORK_AW'(j_reg)];
                if (last_j) begin
                    res_st_next = csbp_pkg::ST_OK;
                    state_next  = ST_DONE;
                end else begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_data_next  = res_data_reg;
                    m_st_next    = res_st_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        addr_reg     <= addr_next;
        cnt_reg      <= cnt_next;
        k_reg        <= k_next;
        k1_reg       <= k1_next;
        q_reg        <= q_next;
        i_reg        <= i_next;
        limit_reg    <= limit_next;
        cyc_reg      <= cyc_next;
        j_reg        <= j_next;
        dst_base_reg <= dst_base_next;
        src_base_reg <= src_base_next;
        prod_reg     <= prod_next;
        plen_reg     <= plen_next;
        res_data_reg <= res_data_next;
        res_st_reg   <= res_st_next;
        m_data_reg   <= m_data_next;
        m_st_reg     <= m_st_next;
    end

    always_ff @(posedge aclk) begin
        if (work_we) begin
            work_reg[csbp_pkg::WORK_AW'(s_addr)] <= {s_im, s_re};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_st_reg;

`ifndef SYNTHESIS
    // modmul result only arrives while the sequencer waits for it
    a_mm_done: assert property (@(posedge aclk) disable iff (!aresetn)
        mm_rsp.done |-> (state_reg == ST_MMWAIT))
        else $error("modmul done outside wait state");

    // element index stays inside the block during copies and workspace store
    a_j_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_CP_WR) || (state_reg == ST_FIN_WR)) |->
        (j_reg < cfg.block_len))
        else $error("block element index out of range");

    // chain position never leaves 0..q-1
    a_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN_BASE) |-> (k_reg < q_reg))
        else $error("chain block index not below q");

    // a finished result is posted and the block reopens
    a_post: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_DONE) && out_free) |=>
        (m_tvalid && (state_reg == ST_IDLE)))
        else $error("result not posted from done state");
`endif

endmodule

`default_nettype wire

### rtl/csbp_ram.sv
// ----------------------------------------------------------------------------
// csbp_ram - generic simple dual port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module csbp_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/csbp_regs.sv
// ----------------------------------------------------------------------------
// csbp_regs - APB configuration registers
// rows, cols and block_len; all reset to one, read back zero-extended.
// ----------------------------------------------------------------------------
`default_nettype none

module csbp_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [csbp_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [csbp_pkg::APB_DW-1:0]   pwdata,
    output logic      [csbp_pkg::APB_DW-1:0]   prdata,
    output logic                               pready,
    output csbp_pkg::cfg_t                     cfg
);

    csbp_pkg::cfg_t cfg_reg, cfg_next;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (paddr[3:2])
                csbp_pkg::REG_ROWS: cfg_next.rows      = pwdata[csbp_pkg::ROWS_W-1:0];
                csbp_pkg::REG_COLS: cfg_next.cols      = pwdata[csbp_pkg::COLS_W-1:0];
                csbp_pkg::REG_BLEN: cfg_next.block_len = pwdata[csbp_pkg::LEN_W-1:0];
                default: ;  // unused index, ignored
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            csbp_pkg::REG_ROWS: prdata = csbp_pkg::APB_DW'(cfg_reg.rows);
            csbp_pkg::REG_COLS: prdata = csbp_pkg::APB_DW'(cfg_reg.cols);
            csbp_pkg::REG_BLEN: prdata = csbp_pkg::APB_DW'(cfg_reg.block_len);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rows      <= csbp_pkg::ROWS_W'(1);
            cfg_reg.cols      <= csbp_pkg::COLS_W'(1);
            cfg_reg.block_len <= csbp_pkg::LEN_W'(1);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

### rtl/csbp_modmul.sv
// ----------------------------------------------------------------------------
// csbp_modmul - bit-serial modular multiplier
// prod = (k * mult) mod modulus, one multiplier bit per cycle, MSB first.
// Needs k < modulus; done pulses one cycle with the result.
// ----------------------------------------------------------------------------
`default_nettype none

module csbp_modmul (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire csbp_pkg::mm_req_t req,
    output csbp_pkg::mm_rsp_t      rsp
);

    localparam int TW = csbp_pkg::MM_T_W;

    logic [csbp_pkg::BLK_W-1:0]  acc_reg, acc_next;
    logic [csbp_pkg::BLK_W-1:0]  k_reg, k_next;
    logic [csbp_pkg::BLK_W-1:0]  q_reg, q_next;
    logic [csbp_pkg::ROWS_W-1:0] mult_reg, mult_next;
    logic [csbp_pkg::MM_BW-1:0]  bit_reg, bit_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;

    logic [TW-1:0] t_sum;
    logic [TW-1:0] q1;
    logic [TW-1:0] q2;
    logic [TW-1:0] t_red;

    // acc < q, so 2*acc + k < 3*q: at most one of q or 2q comes off
    always_comb begin
        q1    = TW'(q_reg);
        q2    = TW'(q_reg) << 1;
        t_sum = (TW'(acc_reg) << 1) + (mult_reg[bit_reg] ? TW'(k_reg) : '0);
        if (t_sum >= q2) begin
            t_red = t_sum - q2;
        end else if (t_sum >= q1) begin
            t_red = t_sum - q1;
        end else begin
            t_red = t_sum;
        end
    end

    always_comb begin
        acc_next  = acc_reg;
        k_next    = k_reg;
        q_next    = q_reg;
        mult_next = mult_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            acc_next  = '0;
            k_next    = req.k;
            q_next    = req.modulus;
            mult_next = req.mult;
            bit_next  = csbp_pkg::MM_BW'(csbp_pkg::ROWS_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            acc_next = csbp_pkg::BLK_W'(t_red);
            if (bit_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                bit_next = bit_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        acc_reg  <= acc_next;
        k_reg    <= k_next;
        q_reg    <= q_next;
        mult_reg <= mult_next;
        bit_reg  <= bit_next;
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

endmodule

`default_nettype wire
